// File: design/b32c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_pkg: shared types and constants of the base32 codec
// Register indexes, the alphabet layout, payload structs and the
// request-group record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package b32c_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA3 = 3'd4;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // most results one request can cause
  localparam int unsigned MAX_RESULTS = 3;

  // 32 characters, character i in bits 8i+7..8i
  typedef logic [31:0][7:0] alphabet_t;

  typedef struct packed {
    logic [7:0] in_value;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
  } out_item_t;

  // results of one request: symbol indexes (encode) or bytes (decode)
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] vals;
    logic [1:0]                  cnt;
    logic                        last;
  } res_group_t;

endpackage

// File: design/b32c_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_fifo: short result-group queue
// Register-based FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module b32c_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  b32c_pkg::res_group_t push_data,
  output logic                 full,
  output logic                 head_valid,
  output b32c_pkg::res_group_t head_data,
  input  logic                 pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b32c_pkg::res_group_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

// File: design/b32c_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_front: request intake and bit repacking
// Accepts one request a cycle while the result queue is not full, updates
// the bit buffer and queues the group of results that the request causes.
// ----------------------------------------------------------------------------
module b32c_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode,
  input  b32c_pkg::alphabet_t   alphabet,
  input  logic                  clear,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  b32c_pkg::in_item_t    in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output b32c_pkg::res_group_t  q_data
);

  logic [11:0] bit_buffer;
  logic [3:0]  bit_count;
  logic [11:0] bit_buffer_next;
  logic [3:0]  bit_count_next;

  logic        accept;
  logic [4:0]  code;
  logic [11:0] full_bits;
  logic [11:0] rem_mask;
  logic [11:0] rem_bits;
  logic [3:0]  total;
  logic [3:0]  rem;
  logic        pad;
  logic [7:0]  first_val;
  logic [7:0]  second_val;
  logic [7:0]  pad_val;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // reverse alphabet lookup, lowest matching index wins
  always_comb begin
    code = '0;
    for (int j = 31; j >= 0; j--) begin
      if (alphabet[j] == in_data.in_value) begin
        code = 5'(j);
      end
    end
  end

  always_comb begin
    q_data     = '0;
    first_val  = '0;
    second_val = '0;
    if (mode == b32c_pkg::MODE_ENCODE) begin
      full_bits  = {bit_buffer[3:0], in_data.in_value};
      total      = bit_count + 4'd8;
      rem        = (total >= 4'd10) ? total - 4'd10 : total - 4'd5;
      first_val  = {3'b000, 5'(full_bits >> (total - 4'd5))};
      second_val = {3'b000, 5'(full_bits >> (total - 4'd10))};
    end else begin
      full_bits  = {bit_buffer[6:0], code};
      total      = bit_count + 4'd5;
      rem        = (total >= 4'd8) ? total - 4'd8 : total;
      first_val  = 8'(full_bits >> (total - 4'd8));
    end
    rem_mask = (12'd1 << rem) - 12'd1;
    rem_bits = full_bits & rem_mask;
    pad      = in_data.in_last && (rem != 4'd0);
    if (mode == b32c_pkg::MODE_ENCODE) begin
      pad_val = {3'b000, 5'(rem_bits << (4'd5 - rem))};
    end else begin
      pad_val = 8'(rem_bits << (4'd8 - rem));
    end

    q_data.last = in_data.in_last;
    if (mode == b32c_pkg::MODE_ENCODE) begin
      q_data.vals[0] = first_val;
      if (total >= 4'd10) begin
        q_data.vals[1] = second_val;
        q_data.vals[2] = pad_val;
        q_data.cnt     = pad ? 2'd3 : 2'd2;
      end else begin
        q_data.vals[1] = pad_val;
        q_data.cnt     = pad ? 2'd2 : 2'd1;
      end
    end else if (total >= 4'd8) begin
      q_data.vals[0] = first_val;
      q_data.vals[1] = pad_val;
      q_data.cnt     = pad ? 2'd2 : 2'd1;
    end else begin
      q_data.vals[0] = pad_val;
      q_data.cnt     = pad ? 2'd1 : 2'd0;
    end

    q_push = accept && (q_data.cnt != 2'd0);

    bit_buffer_next = bit_buffer;
    bit_count_next  = bit_count;
    if (clear) begin
      bit_buffer_next = '0;
      bit_count_next  = '0;
    end else if (accept) begin
      bit_buffer_next = in_data.in_last ? '0 : rem_bits;
      bit_count_next  = in_data.in_last ? '0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_count  <= '0;
    end else begin
      bit_buffer <= bit_buffer_next;
      bit_count  <= bit_count_next;
    end
  end

`ifndef SYNTHESIS
  a_enc_count: assert property (@(posedge clk) disable iff (rst)
    (mode == b32c_pkg::MODE_ENCODE) |-> (bit_count <= 4'd4))
    else $error("encode pending count out of range");
  a_dec_count: assert property (@(posedge clk) disable iff (rst)
    (mode == b32c_pkg::MODE_DECODE) |-> (bit_count <= 4'd7))
    else $error("decode pending count out of range");
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.in_last) |-> (q_push ##1 (bit_count == 4'd0)))
    else $error("last request did not flush");
`endif

endmodule

// File: design/b32c_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32c_back: result sequencer
// Unpacks queued result groups, one result a cycle unless the output stalls,
// maps symbol indexes through the alphabet when encoding and drives the output register.
// ----------------------------------------------------------------------------
module b32c_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode,
  input  b32c_pkg::alphabet_t   alphabet,
  input  logic                  q_valid,
  input  b32c_pkg::res_group_t  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b32c_pkg::out_item_t   out_data
);

  logic [1:0] pos;
  logic       load;
  logic       final_one;
  logic [7:0] raw;

  assign load      = q_valid && (!out_valid || !out_stall);
  assign final_one = (pos == q_data.cnt - 2'd1);
  assign q_pop     = load && final_one;
  assign raw       = q_data.vals[pos];

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_value <= (mode == b32c_pkg::MODE_ENCODE) ? alphabet[raw[4:0]] : raw;
      out_data.out_last  <= q_data.last && final_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos <= final_one ? 2'd0 : pos + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_in_group: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (pos < q_data.cnt))
    else $error("result position beyond queued group");
`endif

endmodule

// File: design/base32_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_codec_top: configurable base32 encoder / decoder
// Repacks bytes into 5-bit alphabet symbols or symbols back into bytes.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the result queue has room. Each
// request is repacked in the cycle it is accepted, its result group is
// registered in the queue, and its results leave the output register one per
// cycle while the output is not stalled. The output sequencer sets throughput:
// encoding yields one or two symbols per byte, eight symbols for every five
// bytes (three for a last byte that leaves a padded symbol), decoding at most
// one byte per symbol (two for a last symbol that leaves a padded byte).
// Writing the mode register drops the pending bits in the front end; the user
// must write registers only while the block is idle, the block does not enforce it.
module base32_codec_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [b32c_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [b32c_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  b32c_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output b32c_pkg::out_item_t                    out_data
);

  logic                 mode;
  b32c_pkg::alphabet_t  alphabet;
  logic                 clear;
  logic                 q_push;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  b32c_pkg::res_group_t q_in;
  b32c_pkg::res_group_t q_head;

  assign clear = cfg_write && (cfg_index == b32c_pkg::REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= b32c_pkg::MODE_ENCODE;
      alphabet <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        b32c_pkg::REG_MODE:   mode            <= cfg_data[0];
        b32c_pkg::REG_ALPHA0: alphabet[7:0]   <= cfg_data;
        b32c_pkg::REG_ALPHA1: alphabet[15:8]  <= cfg_data;
        b32c_pkg::REG_ALPHA2: alphabet[23:16] <= cfg_data;
        b32c_pkg::REG_ALPHA3: alphabet[31:24] <= cfg_data;
        default:              mode            <= mode;
      endcase
    end
  end

  b32c_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .alphabet (alphabet),
    .clear    (clear),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  b32c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop)
  );

  b32c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .alphabet  (alphabet),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
